// ===== rtl/core/button_gesture_detector_macros.svh =====
// Assertion macros shared by the button gesture detector RTL.
`ifndef BUTTON_GESTURE_DETECTOR_MACROS_SVH
`define BUTTON_GESTURE_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bgd_pkg.sv =====
`default_nettype none

package bgd_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd400;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd5000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_GROUP = 2'd1,
    EVT_LONG  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce;
    logic [CFG_W-1:0] window;
    logic [CFG_W-1:0] hold;
  } cfg_t;

  typedef struct packed {
    event_kind_t        kind;
    logic [COUNT_W-1:0] count;
    logic               level;
  } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bgd_in_if.sv =====
`default_nettype none

interface bgd_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bgd_out_if.sv =====
`default_nettype none

interface bgd_out_if;
  import bgd_pkg::*;

  logic               valid;
  logic               ready;
  event_kind_t        event_kind;
  logic [COUNT_W-1:0] press_count;
  logic               stable_level;

  modport source (output valid, output event_kind, output press_count, output stable_level,
                  input ready);
  modport sink (input valid, input event_kind, input press_count, input stable_level,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bgd_cfg_regs.sv =====
`default_nettype none

module bgd_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bgd_pkg::CFG_W-1:0]     cfg_wdata,
  output bgd_pkg::cfg_t                      cfg
);
  import bgd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= DEBOUNCE_RST;
      cfg_r.window   <= WINDOW_RST;
      cfg_r.hold     <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce <= cfg_wdata;
        CFG_WINDOW:   cfg_r.window   <= cfg_wdata;
        CFG_HOLD:     cfg_r.hold     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/bgd_step.sv =====
`default_nettype none

module bgd_step #(
  parameter int TIME_WIDTH = 17
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire logic    level,
  input  wire bgd_pkg::cfg_t cfg,
  output bgd_pkg::step_res_t res
);
  import bgd_pkg::*;

  localparam int CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  logic                  raw_r, raw_nxt;
  logic                  deb_r, deb_nxt;
  logic                  lpd_r, lpd_nxt;
  logic [TIME_WIDTH-1:0] slc_r, slc_nxt;
  logic [TIME_WIDTH-1:0] held_r, held_nxt;
  logic [TIME_WIDTH-1:0] slr_r, slr_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  event_kind_t           kind;
  logic [COUNT_W-1:0]    count_out;

  function automatic logic [TIME_WIDTH-1:0] sat_inc(input logic [TIME_WIDTH-1:0] v);
    return (v == '1) ? v : v + TIME_WIDTH'(1);
  endfunction

  always_comb begin
    raw_nxt   = level;
    deb_nxt   = deb_r;
    lpd_nxt   = lpd_r;
    cnt_nxt   = cnt_r;
    slc_nxt   = sat_inc(slc_r);
    held_nxt  = sat_inc(held_r);
    slr_nxt   = sat_inc(slr_r);
    kind      = EVT_NONE;
    count_out = '0;

    if (level != raw_r) begin
      slc_nxt = '0;
    end

    if ((CW'(slc_nxt) > CW'(cfg.debounce)) && (deb_r != level)) begin
      deb_nxt = level;
      slc_nxt = '0;
      if (!level) begin
        held_nxt = '0;
        lpd_nxt  = 1'b0;
      end else if (!lpd_r && (CW'(held_nxt) < CW'(cfg.hold))) begin
        if (CW'(slr_nxt) <= CW'(cfg.window)) begin
          if (cnt_r != COUNT_MAX) begin
            cnt_nxt = cnt_r + COUNT_W'(1);
          end
        end else begin
          cnt_nxt = COUNT_W'(1);
        end
        slr_nxt = '0;
      end
    end

    if (!deb_nxt && !lpd_nxt && (CW'(held_nxt) >= CW'(cfg.hold))) begin
      lpd_nxt = 1'b1;
      cnt_nxt = '0;
      kind    = EVT_LONG;
    end

    if (deb_nxt && (cnt_nxt != '0) && (CW'(slr_nxt) > CW'(cfg.window))) begin
      kind      = EVT_GROUP;
      count_out = cnt_nxt;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r  <= 1'b1;
      deb_r  <= 1'b1;
      lpd_r  <= 1'b0;
      slc_r  <= '0;
      held_r <= '0;
      slr_r  <= '0;
      cnt_r  <= '0;
    end else if (en) begin
      raw_r  <= raw_nxt;
      deb_r  <= deb_nxt;
      lpd_r  <= lpd_nxt;
      slc_r  <= slc_nxt;
      held_r <= held_nxt;
      slr_r  <= slr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign res.kind  = kind;
  assign res.count = count_out;
  assign res.level = deb_nxt;

endmodule

`default_nettype wire

// ===== rtl/core/button_gesture_detector.sv =====
// A tick passes from the input register into the result register when the result register
// is empty or its result is taken, and is then offered on the output channel.
// Throughput: one tick per cycle; the input register and the result register let a new
// tick enter every cycle while the result side is taking transfers.
// Reset: synchronous, active low; registers return to 50, 400 and 5000, the button reads
// as released, all counters clear and both channel registers empty.
`default_nettype none

`include "button_gesture_detector_macros.svh"

module button_gesture_detector #(
  parameter int TIME_WIDTH = 17
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  bgd_in_if.sink                             in_ch,
  bgd_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bgd_pkg::CFG_W-1:0]     cfg_wdata
);
  import bgd_pkg::*;

  cfg_t      cfg;
  step_res_t res;

  logic               s1_valid_r;
  logic               s1_level_r;
  logic               out_valid_r;
  event_kind_t        out_kind_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_level_r;
  logic               advance;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;

  bgd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bgd_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .level (s1_level_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_level_r <= in_ch.button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r  <= res.kind;
      out_count_r <= res.count;
      out_level_r <= res.level;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.press_count  = out_count_r;
  assign out_ch.stable_level = out_level_r;

  `BGD_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_r, "result register not loaded")
  `BGD_ASSERT_IMPLY(a_group_has_count, clk, rst_n, out_valid_r && (out_kind_r == EVT_GROUP), out_count_r != '0, "press group event with zero count")
  `BGD_ASSERT_IMPLY(a_count_only_group, clk, rst_n, out_valid_r && (out_kind_r != EVT_GROUP), out_count_r == '0, "press count without press group event")
  `BGD_ASSERT_IMPLY(a_long_while_down, clk, rst_n, out_valid_r && (out_kind_r == EVT_LONG), !out_level_r, "long press reported while released")

endmodule

`default_nettype wire
